// ===== hdl/lct_pkg.sv =====
package lct_pkg;

  // Width of the number fields.
  localparam int NUM_W = 63;
  // Width that sets the overflow limit.
  localparam int VALUE_BITS = 63;
  // Decimal digits needed for any NUM_W-bit value.
  localparam int DIGITS = (NUM_W * 30103) / 100000 + 1;
  localparam int BCD_W = 4 * DIGITS;
  localparam int CNT_W = $clog2(NUM_W);

  localparam logic [NUM_W-1:0] MAX_VALUE = NUM_W'((65'd1 << VALUE_BITS) - 65'd1);
  localparam logic [CNT_W-1:0] CONV_LAST = CNT_W'(NUM_W - 1);
  localparam logic [CNT_W-1:0] ADD_LAST = CNT_W'(DIGITS - 1);

  // Reversal guard limits (MAX - d) / 10, one per decimal digit.
  localparam logic [NUM_W-1:0] LIM_0 = (MAX_VALUE - NUM_W'(0)) / 10;
  localparam logic [NUM_W-1:0] LIM_1 = (MAX_VALUE - NUM_W'(1)) / 10;
  localparam logic [NUM_W-1:0] LIM_2 = (MAX_VALUE - NUM_W'(2)) / 10;
  localparam logic [NUM_W-1:0] LIM_3 = (MAX_VALUE - NUM_W'(3)) / 10;
  localparam logic [NUM_W-1:0] LIM_4 = (MAX_VALUE - NUM_W'(4)) / 10;
  localparam logic [NUM_W-1:0] LIM_5 = (MAX_VALUE - NUM_W'(5)) / 10;
  localparam logic [NUM_W-1:0] LIM_6 = (MAX_VALUE - NUM_W'(6)) / 10;
  localparam logic [NUM_W-1:0] LIM_7 = (MAX_VALUE - NUM_W'(7)) / 10;
  localparam logic [NUM_W-1:0] LIM_8 = (MAX_VALUE - NUM_W'(8)) / 10;
  localparam logic [NUM_W-1:0] LIM_9 = (MAX_VALUE - NUM_W'(9)) / 10;

  // Datapath commands
  typedef struct packed {
    logic load;      // capture request, clear BCD accumulator
    logic conv;      // one binary-to-BCD step
    logic rev_init;  // start a reversal pass
    logic rev_step;  // append one digit to the reversal
    logic commit;    // n <= n + r
    logic add_step;  // one BCD digit of n + r
  } dp_cmd_t;

  // Datapath status
  typedef struct packed {
    logic digit_fail;  // guard trips on current digit
    logic last_digit;  // current digit is the most significant
    logic is_pal;      // n equals its reversal
    logic sum_ovf;     // n + r at or above MAX
  } dp_stat_t;

  function automatic logic [NUM_W-1:0] rev_limit(input logic [3:0] d);
    logic [NUM_W-1:0] lim;
    unique case (d)
      4'd0: lim = LIM_0;
      4'd1: lim = LIM_1;
      4'd2: lim = LIM_2;
      4'd3: lim = LIM_3;
      4'd4: lim = LIM_4;
      4'd5: lim = LIM_5;
      4'd6: lim = LIM_6;
      4'd7: lim = LIM_7;
      4'd8: lim = LIM_8;
      4'd9: lim = LIM_9;
      default: lim = LIM_0;
    endcase
    return lim;
  endfunction

endpackage

// ===== hdl/lychrel_candidate_test.sv =====
// Reverse-and-add Lychrel candidate test.
//
// Request channel: drive in_number and pulse start; the request is taken at
// a rising edge with start high and busy low. busy stays high until the
// result has been produced; one request is worked at a time.
// Result channel: out_valid is high for exactly one cycle with
// out_tested_number (echo of the request) and out_is_candidate
// (1 = limit reached, 0 = palindrome reached). The receiver cannot stall;
// the result is gone after that cycle. busy is already low in that cycle,
// so a new request may be taken then.
// Work runs in order: binary-to-BCD conversion, a reversal setup, a digit-serial
// reversal over the decimal digits of the running value (L digits), and a check.
// Each reverse-and-add round adds a digit-serial BCD add, a setup, a reversal
// and a check. A reversal guard that trips ends the work early. The serial
// digit loops set the run time.
// Reset (rst_n low, synchronous) returns the controller to idle and drops
// any request in progress; no result is emitted for it.
module lychrel_candidate_test (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic [lct_pkg::NUM_W-1:0] in_number,
  output logic                      out_valid,
  output logic [lct_pkg::NUM_W-1:0] out_tested_number,
  output logic                      out_is_candidate
);
  import lct_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Sequencer: conversion, reversal passes, checks, add passes.
  lct_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .done         (out_valid),
    .is_candidate (out_is_candidate),
    .cmd          (cmd),
    .stat         (stat)
  );

  // Value registers: binary and BCD copies of n, the reversal, guards.
  lct_datapath u_dp (
    .clk           (clk),
    .cmd           (cmd),
    .in_number     (in_number),
    .stat          (stat),
    .tested_number (out_tested_number)
  );

endmodule

// ===== hdl/lct_datapath.sv =====
module lct_datapath (
  input  logic                      clk,
  input  lct_pkg::dp_cmd_t          cmd,
  input  logic [lct_pkg::NUM_W-1:0] in_number,
  output lct_pkg::dp_stat_t         stat,
  output logic [lct_pkg::NUM_W-1:0] tested_number
);
  import lct_pkg::*;

  logic [NUM_W-1:0] num_r, num_nxt;    // echo
  logic [NUM_W-1:0] n_r, n_nxt;        // running value
  logic [NUM_W-1:0] sh_r, sh_nxt;      // conversion shifter
  logic [NUM_W-1:0] acc_r, acc_nxt;    // binary reversal
  logic [BCD_W-1:0] nbcd_r, nbcd_nxt;  // n in BCD
  logic [BCD_W-1:0] v_r, v_nxt;        // digits left to reverse
  logic [BCD_W-1:0] rbcd_r, rbcd_nxt;  // reversal in BCD
  logic             carry_r, carry_nxt;

  logic [3:0]       dig;
  logic [NUM_W:0]   sum;
  logic [NUM_W-1:0] acc_x10;
  logic [4:0]       dsum;
  logic [3:0]       sdig;
  logic             scarry;

  // add 3 to every digit at or above 5, then shift in one bit
  function automatic logic [BCD_W-1:0] dabble(input logic [BCD_W-1:0] b, input logic bit_in);
    logic [BCD_W-1:0] t;
    t = b;
    for (int i = 0; i < DIGITS; i++) begin
      if (t[4*i +: 4] >= 4'd5) begin
        t[4*i +: 4] = t[4*i +: 4] + 4'd3;
      end
    end
    return {t[BCD_W-2:0], bit_in};
  endfunction

  assign dig     = v_r[3:0];
  assign acc_x10 = (acc_r << 3) + (acc_r << 1) + NUM_W'(dig);
  assign sum     = {1'b0, n_r} + {1'b0, acc_r};

  assign dsum   = 5'(nbcd_r[3:0]) + 5'(rbcd_r[3:0]) + 5'(carry_r);
  assign scarry = (dsum > 5'd9);
  assign sdig   = scarry ? 4'(dsum - 5'd10) : dsum[3:0];

  assign stat.digit_fail = (acc_r >= rev_limit(dig));
  assign stat.last_digit = (v_r[BCD_W-1:4] == '0);
  assign stat.is_pal     = (n_r == acc_r);
  assign stat.sum_ovf    = (sum >= {1'b0, MAX_VALUE});

  assign tested_number = num_r;

  always_comb begin
    num_nxt   = num_r;
    n_nxt     = n_r;
    sh_nxt    = sh_r;
    acc_nxt   = acc_r;
    nbcd_nxt  = nbcd_r;
    v_nxt     = v_r;
    rbcd_nxt  = rbcd_r;
    carry_nxt = carry_r;
    if (cmd.load) begin
      num_nxt  = in_number;
      n_nxt    = in_number;
      sh_nxt   = in_number;
      nbcd_nxt = '0;
    end
    if (cmd.conv) begin
      nbcd_nxt = dabble(nbcd_r, sh_r[NUM_W-1]);
      sh_nxt   = sh_r << 1;
    end
    if (cmd.rev_init) begin
      v_nxt    = nbcd_r;
      acc_nxt  = '0;
      rbcd_nxt = '0;
    end
    if (cmd.rev_step) begin
      acc_nxt  = acc_x10;
      rbcd_nxt = {rbcd_r[BCD_W-5:0], dig};
      v_nxt    = v_r >> 4;
    end
    if (cmd.commit) begin
      n_nxt     = sum[NUM_W-1:0];
      carry_nxt = 1'b0;
    end
    if (cmd.add_step) begin
      nbcd_nxt  = {sdig, nbcd_r[BCD_W-1:4]};
      rbcd_nxt  = rbcd_r >> 4;
      carry_nxt = scarry;
    end
  end

  always_ff @(posedge clk) begin
    num_r   <= num_nxt;
    n_r     <= n_nxt;
    sh_r    <= sh_nxt;
    acc_r   <= acc_nxt;
    nbcd_r  <= nbcd_nxt;
    v_r     <= v_nxt;
    rbcd_r  <= rbcd_nxt;
    carry_r <= carry_nxt;
  end

endmodule

// ===== hdl/lct_ctrl.sv =====
module lct_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  output logic              done,
  output logic              is_candidate,
  output lct_pkg::dp_cmd_t  cmd,
  input  lct_pkg::dp_stat_t stat
);
  import lct_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CONV  = 3'd1;
  localparam logic [2:0] S_RINIT = 3'd2;
  localparam logic [2:0] S_REV   = 3'd3;
  localparam logic [2:0] S_CHECK = 3'd4;
  localparam logic [2:0] S_ADD   = 3'd5;

  logic [2:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             first_r, first_nxt;
  logic             done_r, done_nxt;
  logic             cand_r, cand_nxt;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    first_nxt = first_r;
    done_nxt  = 1'b0;
    cand_nxt  = cand_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          cnt_nxt   = CONV_LAST;
          first_nxt = 1'b1;
          state_nxt = S_CONV;
        end
      end
      S_CONV: begin
        cmd.conv = 1'b1;
        if (cnt_r == '0) begin
          state_nxt = S_RINIT;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      S_RINIT: begin
        cmd.rev_init = 1'b1;
        state_nxt    = S_REV;
      end
      S_REV: begin
        if (stat.digit_fail) begin
          done_nxt  = 1'b1;
          cand_nxt  = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          cmd.rev_step = 1'b1;
          if (stat.last_digit) begin
            state_nxt = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        first_nxt = 1'b0;
        if (!first_r && stat.is_pal) begin
          done_nxt  = 1'b1;
          cand_nxt  = 1'b0;
          state_nxt = S_IDLE;
        end else if (stat.sum_ovf) begin
          done_nxt  = 1'b1;
          cand_nxt  = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          cmd.commit = 1'b1;
          cnt_nxt    = ADD_LAST;
          state_nxt  = S_ADD;
        end
      end
      S_ADD: begin
        cmd.add_step = 1'b1;
        if (cnt_r == '0) begin
          state_nxt = S_RINIT;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      done_r  <= 1'b0;
      first_r <= 1'b0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
      first_r <= first_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cand_r <= cand_nxt;
  end

  assign busy         = (state_r != S_IDLE);
  assign done         = done_r;
  assign is_candidate = cand_r;

  a_accept_starts_conv: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (state_r == S_CONV))
    else $error("accepted request did not start conversion");

  a_done_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (state_r == S_IDLE))
    else $error("result strobe while still working");

  a_add_pass_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ADD && cnt_r == '0) |=> (state_r == S_RINIT))
    else $error("add pass did not hand over to reversal");

  a_check_after_rev: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CHECK) |-> ($past(state_r) == S_REV))
    else $error("check entered without a finished reversal");

endmodule

// ===== tb/lychrel_verdict_checker.sv =====
`timescale 1ns / 100ps

module lychrel_verdict_checker (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic                      busy,
  input  logic [lct_pkg::NUM_W-1:0] in_number,
  input  logic                      out_valid,
  input  logic [lct_pkg::NUM_W-1:0] out_tested_number,
  input  logic                      out_is_candidate,
  output int                        mismatch_count,
  output int                        pending_count,
  output int                        candidates_seen,
  output int                        palindromes_seen
);
  import lct_pkg::*;

  // Overflow bound, 2^VALUE_BITS - 1, held in 64 bits so n + r never wraps.
  localparam logic [63:0] SUM_CEILING = (64'd1 << VALUE_BITS) - 64'd1;

  typedef struct packed {
    logic [NUM_W-1:0] number;
    logic             candidate;
  } verdict_t;

  verdict_t verdict_q[$];
  int n_mismatch = 0;
  int n_pending = 0;
  int n_cand = 0;
  int n_pal = 0;

  assign mismatch_count   = n_mismatch;
  assign pending_count    = n_pending;
  assign candidates_seen  = n_cand;
  assign palindromes_seen = n_pal;

  // Decimal reversal, LSD first; returns 0 when the next digit would push the
  // partial reversal past the ceiling.
  function automatic bit reverse_decimal(input logic [63:0] value, output logic [63:0] rev);
    logic [63:0] acc;
    logic [63:0] digit;
    acc = 64'd0;
    rev = 64'd0;
    for (int k = 0; k < 20; k++) begin
      digit = value % 64'd10;
      if (acc >= (SUM_CEILING - digit) / 64'd10) return 1'b0;
      acc = acc * 64'd10 + digit;
      value = value / 64'd10;
      if (value == 64'd0) break;
    end
    rev = acc;
    return 1'b1;
  endfunction

  // 1 = limit reached, 0 = palindrome reached. First add is always made.
  function automatic logic lychrel_verdict(input logic [NUM_W-1:0] number);
    logic [63:0] n;
    logic [63:0] r;
    n = 64'(number);
    if (!reverse_decimal(n, r)) return 1'b1;
    // n grows every round, so the overflow guard ends this well inside the bound
    for (int round = 0; round < 1000; round++) begin
      if (n >= SUM_CEILING - r) return 1'b1;
      n = n + r;
      if (!reverse_decimal(n, r)) return 1'b1;
      if (n == r) return 1'b0;
    end
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    verdict_t want;
    if (rst_n) begin
      if (out_valid) begin
        if (verdict_q.size() == 0) begin
          $display("%0t: result with none pending: tested_number %0d is_candidate %0b",
                   $time, out_tested_number, out_is_candidate);
          n_mismatch++;
        end else begin
          want = verdict_q.pop_front();
          if (out_tested_number !== want.number) begin
            $display("%0t: tested_number expected %0d got %0d",
                     $time, want.number, out_tested_number);
            n_mismatch++;
          end
          if (out_is_candidate !== want.candidate) begin
            $display("%0t: is_candidate for %0d expected %0b got %0b",
                     $time, want.number, want.candidate, out_is_candidate);
            n_mismatch++;
          end
          if (want.candidate) n_cand++;
          else n_pal++;
        end
      end
      if (start && !busy) begin
        want.number = in_number;
        want.candidate = lychrel_verdict(in_number);
        verdict_q.push_back(want);
      end
      n_pending = verdict_q.size();
    end
  end

endmodule

// ===== tb/lychrel_candidate_test_test.sv =====
`timescale 1ns / 100ps

module lychrel_candidate_test_test;
  import lct_pkg::*;

  // Generous: ~800 requests at a worst case of ~100 rounds each,
  // taken a few times over.
  localparam int CYCLE_LIMIT = 10_000_000;
  localparam int RANDOM_PER_PHASE = 250;
  localparam logic [NUM_W-1:0] ALL_ONES = '1;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             start;
  logic             busy;
  logic [NUM_W-1:0] in_number;
  logic             out_valid;
  logic [NUM_W-1:0] out_tested_number;
  logic             out_is_candidate;

  int mismatch_count;
  int pending_count;
  int candidates_seen;
  int palindromes_seen;

  int sender_idle_pct = 0;   // chance per cycle that the sender holds off
  int requests_sent = 0;
  int directed_sent = 0;
  int cycle_count = 0;

  always #4 clk = ~clk;

  lychrel_candidate_test dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_number        (in_number),
    .out_valid        (out_valid),
    .out_tested_number(out_tested_number),
    .out_is_candidate (out_is_candidate)
  );

  lychrel_verdict_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_number        (in_number),
    .out_valid        (out_valid),
    .out_tested_number(out_tested_number),
    .out_is_candidate (out_is_candidate),
    .mismatch_count   (mismatch_count),
    .pending_count    (pending_count),
    .candidates_seen  (candidates_seen),
    .palindromes_seen (palindromes_seen)
  );

  // Watchdog: a hung handshake or a lost result ends here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results still pending", $time, pending_count);
      $display("lychrel_candidate_test: mismatch");
      $finish;
    end
  end

  // Present one request and hold it until the block takes it. start is only
  // dropped when an idle gap follows, so it is never lowered and raised in the
  // same step; back-to-back requests keep it high.
  task automatic send_number(input logic [NUM_W-1:0] value);
    int gap;
    gap = 0;
    while ($urandom_range(99) < sender_idle_pct && gap < 40) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_number <= value;
    // busy as seen just after the edge is its value before the edge
    @(posedge clk);
    while (busy) @(posedge clk);
    requests_sent++;
  endtask

  // Random request. Most are shaped to reach deep: a random decimal digit
  // count, or a random bit width, so that small seeds run many rounds before
  // they hit a palindrome or overflow. The rest are full-width noise that
  // mostly trips the guards in the first round or two.
  function automatic logic [NUM_W-1:0] pick_number();
    logic [63:0] value;
    int digits;
    int kind;
    kind = $urandom_range(99);
    value = {$urandom, $urandom};
    if (kind < 45) begin
      digits = $urandom_range(19, 1);
      value = 64'd0;
      for (int k = 0; k < digits; k++) value = value * 64'd10 + 64'($urandom_range(9));
    end else if (kind < 85) begin
      value = value & ((64'd1 << $urandom_range(NUM_W, 1)) - 64'd1);
    end
    return value[NUM_W-1:0];
  endfunction

  initial begin
    logic [NUM_W-1:0] directed[$];

    rst_n <= 1'b0;
    start <= 1'b0;
    in_number <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed set:
    //   zero (reverses to itself, 0 + 0 is a palindrome), single digits,
    //   an input that already is a palindrome (first add still made),
    //   classic slow ones (89, 10911) and known candidates (196, 295, 879,
    //   1997), a 19-digit seed with a long delayed palindrome that overflows
    //   here, a leading digit times a power of ten that lands on a palindrome,
    //   values whose first reversal fails, values right at the reversal guard
    //   edge (reversal equal to or one under the ceiling), one whose reversal
    //   passes but whose first sum overflows, and the field extremes.
    directed = {
      63'd0, 63'd1, 63'd5, 63'd9, 63'd10, 63'd11, 63'd12, 63'd55, 63'd89, 63'd98,
      63'd121, 63'd196, 63'd295, 63'd879, 63'd1997, 63'd10911,
      63'd1186060307891929990, 63'd4000000000000000000,
      63'd1999999999999999999, 63'd7085774586302733229,
      63'd6085774586302733229, 63'd7085774586302733228,
      63'd4611686018427387904, ALL_ONES - 63'd1, ALL_ONES
    };
    foreach (directed[i]) send_number(directed[i]);
    directed_sent = directed.size();

    // Random part in three phases of sender pressure: light idling, heavy
    // idling, then none at all. Results cannot be stalled, so the receiver
    // side has nothing to vary.
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: sender_idle_pct = 12;
        1: sender_idle_pct = 68;
        default: sender_idle_pct = 0;
      endcase
      repeat (RANDOM_PER_PHASE) send_number(pick_number());
    end
    start <= 1'b0;

    // Drain: sample at the falling edge so the checker has already logged the
    // last request taken at the rising edge.
    @(negedge clk);
    while (pending_count != 0) @(negedge clk);
    // Stray results after the last expected one would show up here.
    repeat (200) @(posedge clk);

    $display("Covered %0d requests (%0d directed, rest random over 3 sender idle phases)",
             requests_sent, directed_sent);
    $display("Checked %0d limit-reached and %0d palindrome verdicts, %0d field errors",
             candidates_seen, palindromes_seen, mismatch_count);
    if (mismatch_count == 0) begin
      $display("lychrel_candidate_test: match");
    end else begin
      $display("lychrel_candidate_test: mismatch");
    end
    $finish;
  end

endmodule

// ===== lychrel_candidate_test.f =====
hdl/lct_pkg.sv
hdl/lct_datapath.sv
hdl/lct_ctrl.sv
hdl/lychrel_candidate_test.sv
tb/lychrel_verdict_checker.sv
tb/lychrel_candidate_test_test.sv
